FILE: rtl/sust_pkg.sv
`timescale 1ns / 1ps
package sust_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FIELD_W  = 7;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_FIND   = 3'd2,
    KIND_READ   = 3'd3,
    KIND_UPDATE = 3'd4
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  typedef enum logic [1:0] {
    UPD_NEW_CHK,
    UPD_DEL,
    UPD_INS
  } upd_phase_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
    logic [FIELD_W-1:0]       position;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic [FIELD_W-1:0]       found_position;
    logic signed [DATA_W-1:0] read_value;
    logic [FIELD_W-1:0]       entry_count;
  } out_item_t;

  typedef struct packed {
    logic              cmp_en;
    logic              ins;
    logic              del;
    logic [DATA_W-1:0] key;
  } cell_ctrl_t;

  function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] x);
    logic [CNT_W+FIELD_W-1:0] e;
    e = {{FIELD_W{1'b0}}, x};
    return e[FIELD_W-1:0];
  endfunction

endpackage

FILE: rtl/sust_cell.sv
`timescale 1ns / 1ps
module sust_cell
  import sust_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              in_range,
  input  logic [DATA_W-1:0] left_entry,
  input  logic              left_lt,
  input  logic [DATA_W-1:0] right_entry,
  output logic [DATA_W-1:0] entry_o,
  output logic              lt_o,
  output logic              eq_o
);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic              lt_r;
  logic              eq_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.ins && !lt_r) begin
      entry_nxt = left_lt ? ctrl.key : left_entry;
    end else if (ctrl.del && !lt_r) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.cmp_en) begin
      lt_r <= in_range && ($signed(entry_r) < $signed(ctrl.key));
      eq_r <= in_range && (entry_r == ctrl.key);
    end
  end

  assign entry_o = entry_r;
  assign lt_o    = lt_r;
  assign eq_o    = eq_r;

endmodule

FILE: rtl/sorted_unique_set_table.sv
`timescale 1ns / 1ps
// Ascending set of unique signed 32-bit values, up to CAPACITY entries, kept in
// a row of compare-and-shift cells. An item is taken when start is high and
// busy is low; its result appears on out_word for one cycle with out_strobe
// high and must be captured then. Insert, delete, find, read and unknown
// operations pass a compare state across all cells, then a shift or report
// state; update runs that pair per phase (check new value, find and remove old
// value, insert new value), ending early if a check fails. busy is low in the
// last execute cycle, so a new item may be given there, the cycle before its
// predecessor's result appears. entry_count is the count after the operation.
module sorted_unique_set_table
  import sust_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_word,
  output logic      out_strobe,
  output out_item_t out_word
);

  localparam int PW = CNT_W + FIELD_W;

  state_t                   state_r, state_nxt;
  upd_phase_t               phase_r, phase_nxt;
  logic [2:0]               kind_r;
  logic [DATA_W-1:0]        value_r;
  logic [DATA_W-1:0]        new_value_r;
  logic [FIELD_W-1:0]       pos_r;
  logic [DATA_W-1:0]        key_r, key_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CAPACITY-1:0]      sel_r, sel_nxt;
  logic                     out_strobe_r;
  out_item_t                out_word_r;

  cell_ctrl_t               ctrl;
  logic [CAPACITY-1:0]      in_rng;
  logic [CAPACITY-1:0]      lt;
  logic [CAPACITY-1:0]      eq;
  logic [DATA_W-1:0]        ent [CAPACITY];

  logic                     accept;
  logic                     done;
  logic                     ok_c;
  logic [CNT_W-1:0]         fpos_c;
  logic [DATA_W-1:0]        rval_c;
  logic                     any_eq;
  logic                     not_full;
  logic                     pos_ok;
  logic [CNT_W-1:0]         fpos_enc;
  logic [DATA_W-1:0]        rd_or;

  // cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] l_ent;
    logic              l_lt;
    logic [DATA_W-1:0] r_ent;

    assign in_rng[i] = count_r > CNT_W'(i);
    assign sel_nxt[i] = {{CNT_W{1'b0}}, in_word.position} == PW'(i + 1);

    if (i == 0) begin : g_first
      assign l_ent = key_r;
      assign l_lt  = 1'b1;
    end else begin : g_mid
      assign l_ent = ent[i-1];
      assign l_lt  = lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = key_r;
    end else begin : g_inner
      assign r_ent = ent[i+1];
    end

    sust_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .in_range    (in_rng[i]),
      .left_entry  (l_ent),
      .left_lt     (l_lt),
      .right_entry (r_ent),
      .entry_o     (ent[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  always_comb begin
    fpos_enc = '0;
    rd_or    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i]) begin
        fpos_enc = fpos_enc | CNT_W'(i + 1);
      end
      if (sel_r[i]) begin
        rd_or = rd_or | ent[i];
      end
    end
  end

  assign any_eq   = |eq;
  assign not_full = count_r < CNT_W'(CAPACITY);
  assign pos_ok   = (pos_r != '0) &&
                    ({{CNT_W{1'b0}}, pos_r} <= {{FIELD_W{1'b0}}, count_r});

  // outputs and datapath control
  always_comb begin
    ctrl.cmp_en = (state_r == ST_CMP);
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.key    = key_r;
    done        = 1'b0;
    ok_c        = 1'b0;
    fpos_c      = '0;
    rval_c      = '0;
    count_nxt   = count_r;
    key_nxt     = key_r;
    phase_nxt   = phase_r;
    if (state_r == ST_EXEC) begin
      unique case (kind_r)
        KIND_INSERT: begin
          done = 1'b1;
          if (!any_eq && not_full) begin
            ctrl.ins  = 1'b1;
            ok_c      = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        KIND_DELETE: begin
          done = 1'b1;
          if (any_eq) begin
            ctrl.del  = 1'b1;
            ok_c      = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        KIND_FIND: begin
          done   = 1'b1;
          ok_c   = any_eq;
          fpos_c = fpos_enc;
        end
        KIND_READ: begin
          done   = 1'b1;
          ok_c   = pos_ok;
          rval_c = pos_ok ? rd_or : '0;
        end
        KIND_UPDATE: begin
          unique case (phase_r)
            UPD_NEW_CHK: begin
              if (any_eq) begin
                done = 1'b1;
              end else begin
                key_nxt   = value_r;
                phase_nxt = UPD_DEL;
              end
            end
            UPD_DEL: begin
              if (!any_eq) begin
                done = 1'b1;
              end else begin
                ctrl.del  = 1'b1;
                count_nxt = count_r - 1'b1;
                key_nxt   = new_value_r;
                phase_nxt = UPD_INS;
              end
            end
            UPD_INS: begin
              done = 1'b1;
              if (!any_eq && not_full) begin
                ctrl.ins  = 1'b1;
                ok_c      = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    busy   = (state_r == ST_CMP) || ((state_r == ST_EXEC) && !done);
    accept = start && !busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!done || start) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= in_word.kind;
      value_r     <= in_word.value;
      new_value_r <= in_word.new_value;
      pos_r       <= in_word.position;
      sel_r       <= sel_nxt;
      phase_r     <= UPD_NEW_CHK;
      key_r       <= (in_word.kind == KIND_UPDATE) ? in_word.new_value : in_word.value;
    end else begin
      phase_r     <= phase_nxt;
      key_r       <= key_nxt;
    end
    if (done) begin
      out_word_r.ok             <= ok_c;
      out_word_r.found_position <= to_field(fpos_c);
      out_word_r.read_value     <= rval_c;
      out_word_r.entry_count    <= to_field(count_nxt);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef NO_ASSERTIONS
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(eq))
    else $error("more than one cell matches the key");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CMP))
    else $error("accepted word did not enter compare");

  a_strobe_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == ST_EXEC))
    else $error("result strobe without execute cycle");
`endif

endmodule

FILE: verif/set_table_checker.sv
`timescale 1ns / 1ps
module set_table_checker
  import sust_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_word,
  input  logic      out_strobe,
  input  out_item_t out_word,
  output int        pending,
  output int        failures
);

  logic signed [DATA_W-1:0] set_vals [CAPACITY];
  int                       held;
  out_item_t                result_q [$];
  int                       miss_count;

  assign failures = miss_count;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    miss_count++;
  endtask

  // index of the first held value >= v, or held if none
  function automatic int slot_of(input logic signed [DATA_W-1:0] v);
    int i;
    for (i = 0; i < held; i++) begin
      if (set_vals[i] >= v) break;
    end
    return i;
  endfunction

  function automatic int locate(input logic signed [DATA_W-1:0] v);
    int i;
    i = slot_of(v);
    if (i < held && set_vals[i] == v) return i + 1;
    return 0;
  endfunction

  function automatic bit put_val(input logic signed [DATA_W-1:0] v);
    int i;
    i = slot_of(v);
    if (i < held && set_vals[i] == v) return 1'b0;
    if (held >= CAPACITY) return 1'b0;
    for (int j = held; j > i; j--) set_vals[j] = set_vals[j-1];
    set_vals[i] = v;
    held++;
    return 1'b1;
  endfunction

  function automatic bit drop_val(input logic signed [DATA_W-1:0] v);
    int p;
    p = locate(v);
    if (p == 0) return 1'b0;
    for (int j = p - 1; j < held - 1; j++) set_vals[j] = set_vals[j+1];
    held--;
    return 1'b1;
  endfunction

  function automatic out_item_t apply_op(input in_item_t w);
    out_item_t                r;
    int                       p;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] nv;
    r  = '0;
    v  = w.value;
    nv = w.new_value;
    case (w.kind)
      KIND_INSERT: r.ok = put_val(v);
      KIND_DELETE: r.ok = drop_val(v);
      KIND_FIND: begin
        p = locate(v);
        r.ok = (p != 0);
        r.found_position = p[FIELD_W-1:0];
      end
      KIND_READ: begin
        if (int'(w.position) >= 1 && int'(w.position) <= held) begin
          r.ok = 1'b1;
          r.read_value = set_vals[int'(w.position) - 1];
        end
      end
      KIND_UPDATE: begin
        if (locate(nv) == 0) begin
          if (drop_val(v)) r.ok = put_val(nv);
        end
      end
      default: ;
    endcase
    r.entry_count = held[FIELD_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held = 0;
      result_q.delete();
    end else begin
      if (out_strobe) begin
        if (result_q.size() == 0) begin
          report_mismatch("word with none pending", DATA_W'(out_word.entry_count), '0);
        end else begin
          want = result_q.pop_front();
          if (out_word.ok !== want.ok)
            report_mismatch("ok", DATA_W'(out_word.ok), DATA_W'(want.ok));
          if (out_word.found_position !== want.found_position)
            report_mismatch("found_position", DATA_W'(out_word.found_position),
                            DATA_W'(want.found_position));
          if (out_word.read_value !== want.read_value)
            report_mismatch("read_value", out_word.read_value, want.read_value);
          if (out_word.entry_count !== want.entry_count)
            report_mismatch("entry_count", DATA_W'(out_word.entry_count),
                            DATA_W'(want.entry_count));
        end
      end
      if (start && !busy) result_q.push_back(apply_op(in_word));
    end
    pending <= result_q.size();
  end

endmodule

FILE: verif/sorted_unique_set_table_tb.sv
`timescale 1ns / 1ps
module sorted_unique_set_table_tb;
  import sust_pkg::*;

  localparam int KIND_CODES     = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int WINDOW         = 96;
  localparam int FILL_WORDS     = 190;
  localparam int DRAIN_WORDS    = 120;
  localparam int PAIRS          = 4;
  localparam int TAIL_CYCLES    = 8;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_word;
  logic      out_strobe;
  out_item_t out_word;
  int        pending;
  int        fail_count;

  sorted_unique_set_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  set_table_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .pending    (pending),
    .failures   (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic in_item_t make_word(input logic [2:0] k, input logic [DATA_W-1:0] v,
                                         input logic [DATA_W-1:0] nv,
                                         input logic [FIELD_W-1:0] pos);
    in_item_t w;
    w.kind      = k;
    w.value     = v;
    w.new_value = nv;
    w.position  = pos;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_val(input logic [DATA_W-1:0] center);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return center + $urandom_range(0, WINDOW - 1) - WINDOW / 2;
    if (r < 96) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '1;
      default: return '0;
    endcase
  endfunction

  function automatic in_item_t rand_word(input bit fill, input logic [DATA_W-1:0] center);
    int         r;
    logic [2:0] k;
    in_item_t   w;
    r = $urandom_range(0, 99);
    if (fill) begin
      if (r < 72)      k = KIND_INSERT;
      else if (r < 78) k = KIND_DELETE;
      else if (r < 86) k = KIND_FIND;
      else if (r < 92) k = KIND_READ;
      else if (r < 97) k = KIND_UPDATE;
      else             k = 3'($urandom_range(int'(KIND_UPDATE) + 1, KIND_CODES - 1));
    end else begin
      if (r < 12)      k = KIND_INSERT;
      else if (r < 60) k = KIND_DELETE;
      else if (r < 74) k = KIND_FIND;
      else if (r < 86) k = KIND_READ;
      else if (r < 97) k = KIND_UPDATE;
      else             k = 3'($urandom_range(int'(KIND_UPDATE) + 1, KIND_CODES - 1));
    end
    w = make_word(k, pick_val(center), pick_val(center),
                  FIELD_W'($urandom_range(0, (1 << FIELD_W) - 1)));
    if (k == KIND_READ && $urandom_range(0, 99) < 80)
      w.position = FIELD_W'($urandom_range(1, CAPACITY + 2));
    return w;
  endfunction

  task automatic issue(input in_item_t w, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 99) < 9) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet = 0;
      else quiet++;
    end
    $display("sorted_unique_set_table regression: fail");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] center;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(make_word(KIND_READ, 0, 0, 0), 1'b0);
    issue(make_word(KIND_READ, 0, 0, 1), 1'b0);
    issue(make_word(KIND_FIND, 0, 0, 0), 1'b0);
    issue(make_word(KIND_DELETE, 5, 0, 0), 1'b0);
    issue(make_word(KIND_UPDATE, 1, 2, 0), 1'b0);
    issue(make_word(KIND_INSERT, VAL_MAX, 0, 0), 1'b0);
    issue(make_word(KIND_INSERT, VAL_MIN, 0, 0), 1'b0);
    issue(make_word(KIND_INSERT, 0, 0, 0), 1'b0);
    issue(make_word(KIND_INSERT, 0, 0, 0), 1'b0);
    issue(make_word(KIND_FIND, VAL_MIN, 0, 0), 1'b0);
    issue(make_word(KIND_FIND, VAL_MAX, 0, 0), 1'b0);
    issue(make_word(KIND_READ, 0, 0, 3), 1'b0);
    issue(make_word(KIND_READ, 0, 0, 4), 1'b0);
    issue(make_word(KIND_READ, '1, '1, '1), 1'b0);
    issue(make_word(KIND_UPDATE, 0, 0, 0), 1'b0);
    issue(make_word(KIND_UPDATE, 0, VAL_MAX, 0), 1'b0);
    issue(make_word(KIND_UPDATE, 0, -5, 0), 1'b0);
    issue(make_word(KIND_UPDATE, -5, 32'h5555_5555, 0), 1'b0);
    for (int k = int'(KIND_UPDATE) + 1; k < KIND_CODES; k++)
      issue(make_word(3'(k), $urandom, $urandom, FIELD_W'($urandom)), 1'b0);
    issue(make_word(KIND_DELETE, VAL_MAX, 0, 0), 1'b0);
    issue(make_word(KIND_DELETE, VAL_MAX, 0, 0), 1'b0);
    issue(make_word(KIND_FIND, '1, 0, 0), 1'b0);
    wait_drained();

    for (int pair = 0; pair < PAIRS; pair++) begin
      case (pair)
        0:       center = '0;
        1:       center = VAL_MIN + WINDOW / 2;
        2:       center = VAL_MAX - (WINDOW / 2 - 1);
        default: center = $urandom;
      endcase
      for (int n = 0; n < FILL_WORDS; n++) issue(rand_word(1'b1, center), pair != 1);
      wait_drained();
      for (int n = 0; n < DRAIN_WORDS; n++) issue(rand_word(1'b0, center), 1'b1);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_unique_set_table regression: pass");
    end else begin
      $display("sorted_unique_set_table regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sust_pkg.sv
rtl/sust_cell.sv
rtl/sorted_unique_set_table.sv
verif/set_table_checker.sv
verif/sorted_unique_set_table_tb.sv
